// File: rtl/tlqe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlqe_pkg
// Shared constants for the thick line quad expansion core.
// ----------------------------------------------------------------------------
package tlqe_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int PEN_W          = 8;
  localparam logic [PEN_W-1:0] PEN_RESET = 8'd1;

  // length is taken in q.8: squared length scaled by 2^16 before the root
  localparam int LEN_SHIFT = 16;
  localparam int DIFF_MAX_W = 16;

  // root and quotient bits produced per pipeline stage
  localparam int SQRT_STEP = 4;
  localparam int DIV_STEP  = 4;

  localparam logic KIND_LINE  = 1'b0;
  localparam logic KIND_STRIP = 1'b1;

  localparam logic [2:0] THIN_COUNT  = 3'd2;
  localparam logic [2:0] THICK_COUNT = 3'd4;

endpackage

// File: rtl/tlqe_sqrt_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlqe_sqrt_pipe
// Pipelined integer square root, a few root bits per stage, tag carried along.
// ----------------------------------------------------------------------------
module tlqe_sqrt_pipe #(
  parameter int IN_W  = 50,
  parameter int TAG_W = 8,
  parameter int STEP  = tlqe_pkg::SQRT_STEP
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [IN_W-1:0]   in_rad,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  output logic [IN_W/2-1:0] out_root,
  output logic [TAG_W-1:0]  out_tag
);
  localparam int R_W   = IN_W / 2;
  localparam int REM_W = R_W + 3;
  localparam int NSTG  = (R_W + STEP - 1) / STEP;

  logic [NSTG-1:0]  v_r;
  logic [NSTG-1:0]  v_nxt;
  logic [IN_W-1:0]  n_r     [NSTG];
  logic [IN_W-1:0]  n_nxt   [NSTG];
  logic [REM_W-1:0] rem_r   [NSTG];
  logic [REM_W-1:0] rem_nxt [NSTG];
  logic [R_W-1:0]   root_r  [NSTG];
  logic [R_W-1:0]   root_nxt[NSTG];
  logic [TAG_W-1:0] tag_r   [NSTG];
  logic [TAG_W-1:0] tag_nxt [NSTG];

  always_comb begin
    logic [IN_W-1:0]  n;
    logic [REM_W-1:0] rem;
    logic [REM_W-1:0] trial;
    logic [R_W-1:0]   root;
    for (int s = 0; s < NSTG; s++) begin
      if (s == 0) begin
        n          = in_rad;
        rem        = '0;
        root       = '0;
        v_nxt[s]   = in_valid;
        tag_nxt[s] = in_tag;
      end else begin
        n          = n_r[s-1];
        rem        = rem_r[s-1];
        root       = root_r[s-1];
        v_nxt[s]   = v_r[s-1];
        tag_nxt[s] = tag_r[s-1];
      end
      for (int j = 0; j < STEP; j++) begin
        if (s * STEP + j < R_W) begin
          rem   = {rem[REM_W-3:0], n[IN_W-1:IN_W-2]};
          n     = {n[IN_W-3:0], 2'b00};
          trial = {1'b0, root, 2'b01};
          if (rem >= trial) begin
            rem  = rem - trial;
            root = {root[R_W-2:0], 1'b1};
          end else begin
            root = {root[R_W-2:0], 1'b0};
          end
        end
      end
      n_nxt[s]    = n;
      rem_nxt[s]  = rem;
      root_nxt[s] = root;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NSTG; s++) begin
      n_r[s]    <= n_nxt[s];
      rem_r[s]  <= rem_nxt[s];
      root_r[s] <= root_nxt[s];
      tag_r[s]  <= tag_nxt[s];
    end
  end

  assign out_valid = v_r[NSTG-1];
  assign out_root  = root_r[NSTG-1];
  assign out_tag   = tag_r[NSTG-1];

endmodule

// File: rtl/tlqe_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlqe_div_pipe
// Two-lane pipelined restoring divider sharing one divisor, tag carried along.
// ----------------------------------------------------------------------------
module tlqe_div_pipe #(
  parameter int Q_W   = 23,
  parameter int D_W   = 26,
  parameter int P_W   = 24,
  parameter int TAG_W = 8,
  parameter int STEP  = tlqe_pkg::DIV_STEP
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [D_W-1:0]   in_den,
  input  logic [P_W-1:0]   in_px,
  input  logic [P_W-1:0]   in_py,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [Q_W-1:0]   out_qx,
  output logic [Q_W-1:0]   out_qy,
  output logic [TAG_W-1:0] out_tag
);
  localparam int RM_W = D_W + 1;
  localparam int NSTG = (Q_W + STEP - 1) / STEP;

  logic [NSTG-1:0]  v_r;
  logic [NSTG-1:0]  v_nxt;
  logic [D_W-1:0]   den_r  [NSTG];
  logic [D_W-1:0]   den_nxt[NSTG];
  logic [RM_W-1:0]  rx_r   [NSTG];
  logic [RM_W-1:0]  rx_nxt [NSTG];
  logic [RM_W-1:0]  ry_r   [NSTG];
  logic [RM_W-1:0]  ry_nxt [NSTG];
  logic [Q_W-1:0]   qx_r   [NSTG];
  logic [Q_W-1:0]   qx_nxt [NSTG];
  logic [Q_W-1:0]   qy_r   [NSTG];
  logic [Q_W-1:0]   qy_nxt [NSTG];
  logic [TAG_W-1:0] tag_r  [NSTG];
  logic [TAG_W-1:0] tag_nxt[NSTG];

  always_comb begin
    logic [D_W-1:0]  den;
    logic [RM_W-1:0] rx;
    logic [RM_W-1:0] ry;
    logic [Q_W-1:0]  qx;
    logic [Q_W-1:0]  qy;
    for (int s = 0; s < NSTG; s++) begin
      if (s == 0) begin
        den        = in_den;
        rx         = RM_W'({in_px, 1'b0});
        ry         = RM_W'({in_py, 1'b0});
        qx         = '0;
        qy         = '0;
        v_nxt[s]   = in_valid;
        tag_nxt[s] = in_tag;
      end else begin
        den        = den_r[s-1];
        rx         = rx_r[s-1];
        ry         = ry_r[s-1];
        qx         = qx_r[s-1];
        qy         = qy_r[s-1];
        v_nxt[s]   = v_r[s-1];
        tag_nxt[s] = tag_r[s-1];
      end
      for (int j = 0; j < STEP; j++) begin
        if (s * STEP + j < Q_W) begin
          rx = {rx[D_W-1:0], 1'b0};
          ry = {ry[D_W-1:0], 1'b0};
          if (rx >= {1'b0, den}) begin
            rx = rx - {1'b0, den};
            qx = {qx[Q_W-2:0], 1'b1};
          end else begin
            qx = {qx[Q_W-2:0], 1'b0};
          end
          if (ry >= {1'b0, den}) begin
            ry = ry - {1'b0, den};
            qy = {qy[Q_W-2:0], 1'b1};
          end else begin
            qy = {qy[Q_W-2:0], 1'b0};
          end
        end
      end
      den_nxt[s] = den;
      rx_nxt[s]  = rx;
      ry_nxt[s]  = ry;
      qx_nxt[s]  = qx;
      qy_nxt[s]  = qy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NSTG; s++) begin
      den_r[s] <= den_nxt[s];
      rx_r[s]  <= rx_nxt[s];
      ry_r[s]  <= ry_nxt[s];
      qx_r[s]  <= qx_nxt[s];
      qy_r[s]  <= qy_nxt[s];
      tag_r[s] <= tag_nxt[s];
    end
  end

  assign out_valid = v_r[NSTG-1];
  assign out_qx    = qx_r[NSTG-1];
  assign out_qy    = qy_r[NSTG-1];
  assign out_tag   = tag_r[NSTG-1];

endmodule

// File: rtl/thick_line_quad_expand_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thick_line_quad_expand_core
// Expands a segment into two line endpoints or four triangle-strip corners.
//
//   channel  handshake               payload
//   request  start / busy            in_start_x, in_start_y, in_end_x, in_end_y
//   result   out_valid strobe        out_vertex_x, out_vertex_y,
//                                    out_primitive_kind, out_last_vertex
//   config   cfg_valid / cfg_ready   cfg_pen_thickness
//
// requests are spaced by busy: the single result port emits up to four
// vertices per request, and busy holds off start after each accept.
// the first vertex strobe follows the accepting edge through request,
// difference, multiply and sum registers, seven root stages, six divider
// stages, then corner, buffer and output registers.
// synchronous active-low reset clears valid bits and counters and loads pen_r.
// results cannot be stalled; nothing in the pipeline ever waits.
// ----------------------------------------------------------------------------
module thick_line_quad_expand_core #(
  parameter int COORD_BITS = tlqe_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = tlqe_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  output logic                         out_valid,
  output logic signed [COORD_BITS-1:0] out_vertex_x,
  output logic signed [COORD_BITS-1:0] out_vertex_y,
  output logic                         out_primitive_kind,
  output logic                         out_last_vertex,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tlqe_pkg::PEN_W-1:0]   cfg_pen_thickness
);
  import tlqe_pkg::*;

  localparam int C       = COORD_BITS;
  localparam int F       = FRAC_BITS;
  localparam int DS      = (C > DIFF_MAX_W) ? C - DIFF_MAX_W : 0;
  localparam int AD_W    = C - DS;
  localparam int P_W     = AD_W + PEN_W;
  localparam int SQ_IN_W = 2 * AD_W + 2 + LEN_SHIFT;
  localparam int R_W     = SQ_IN_W / 2;
  localparam int D_W     = R_W + 1;
  localparam int Q_W     = F + 7;
  localparam int OFF_W   = Q_W + 1;
  localparam int CW      = C + F + 2;
  localparam int V_W     = C + 3;
  localparam int TAG2_W  = 4 * C + 4;
  localparam int TAG1_W  = TAG2_W + 2 * P_W;

  localparam logic signed [V_W-1:0] V_HI = {{(V_W - C + 1){1'b0}}, {(C - 1){1'b1}}};
  localparam logic signed [V_W-1:0] V_LO = {{(V_W - C + 1){1'b1}}, {(C - 1){1'b0}}};

  function automatic logic [C-1:0] to_coord(input logic signed [CW-1:0] q);
    logic [CW-1:0]         m;
    logic signed [V_W-1:0] v;
    logic [C-1:0]          r;
    if (q[CW-1]) begin
      m = -q;
      v = -$signed({1'b0, m[CW-1:F]});
    end else begin
      v = $signed({1'b0, q[CW-1:F]});
    end
    if (v > V_HI) begin
      r = V_HI[C-1:0];
    end else if (v < V_LO) begin
      r = V_LO[C-1:0];
    end else begin
      r = v[C-1:0];
    end
    return r;
  endfunction

  // config and request acceptance
  logic [PEN_W-1:0] pen_r;
  logic [1:0]       gap_r;
  logic             accept;

  assign cfg_ready = 1'b1;
  assign busy      = (gap_r != 2'd0);
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_r <= PEN_RESET;
      gap_r <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        pen_r <= cfg_pen_thickness;
      end
      if (accept) begin
        gap_r <= 2'd3;
      end else if (gap_r != 2'd0) begin
        gap_r <= gap_r - 2'd1;
      end
    end
  end

  // stage a: request registers
  logic             a_v_r;
  logic [C-1:0]     a_x1_r, a_y1_r, a_x2_r, a_y2_r;
  logic [PEN_W-1:0] a_pen_r;
  logic             a_thin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_x1_r   <= in_start_x;
      a_y1_r   <= in_start_y;
      a_x2_r   <= in_end_x;
      a_y2_r   <= in_end_y;
      a_pen_r  <= pen_r;
      a_thin_r <= (pen_r <= PEN_W'(1));
    end
  end

  // stage b: differences and magnitudes
  logic [C:0]       dx, dy, mx_abs, my_abs;
  logic             b_v_r;
  logic [AD_W-1:0]  b_adx_r, b_ady_r;
  logic             b_sx_r, b_sy_r, b_thin_r;
  logic [PEN_W-1:0] b_pen_r;
  logic [C-1:0]     b_x1_r, b_y1_r, b_x2_r, b_y2_r;

  assign dx     = {a_x2_r[C-1], a_x2_r} - {a_x1_r[C-1], a_x1_r};
  assign dy     = {a_y2_r[C-1], a_y2_r} - {a_y1_r[C-1], a_y1_r};
  assign mx_abs = dx[C] ? -dx : dx;
  assign my_abs = dy[C] ? -dy : dy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    b_adx_r  <= AD_W'(mx_abs >> DS);
    b_ady_r  <= AD_W'(my_abs >> DS);
    b_sx_r   <= dx[C];
    b_sy_r   <= dy[C];
    b_thin_r <= a_thin_r;
    b_pen_r  <= a_pen_r;
    b_x1_r   <= a_x1_r;
    b_y1_r   <= a_y1_r;
    b_x2_r   <= a_x2_r;
    b_y2_r   <= a_y2_r;
  end

  // stage c: squares and scaled magnitudes
  logic              c_v_r;
  logic [2*AD_W-1:0] c_sqx_r, c_sqy_r;
  logic [P_W-1:0]    c_px_r, c_py_r;
  logic [TAG2_W-1:0] c_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    c_sqx_r <= b_adx_r * b_adx_r;
    c_sqy_r <= b_ady_r * b_ady_r;
    c_px_r  <= b_adx_r * b_pen_r;
    c_py_r  <= b_ady_r * b_pen_r;
    c_tag_r <= {b_x1_r, b_y1_r, b_x2_r, b_y2_r, b_sx_r, b_sy_r, b_thin_r, 1'b0};
  end

  // stage d: squared length
  logic                d_v_r;
  logic [2*AD_W:0]     d_l2_r;
  logic [P_W-1:0]      d_px_r, d_py_r;
  logic [TAG2_W-1:0]   d_tag_r;
  logic [SQ_IN_W-1:0]  sq_rad;
  logic [TAG1_W-1:0]   sq_tag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else begin
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    d_l2_r  <= {1'b0, c_sqx_r} + {1'b0, c_sqy_r};
    d_px_r  <= c_px_r;
    d_py_r  <= c_py_r;
    d_tag_r <= c_tag_r;
  end

  assign sq_rad = {1'b0, d_l2_r, {LEN_SHIFT{1'b0}}};
  assign sq_tag = {d_tag_r[TAG2_W-1:1], (d_l2_r == '0), d_px_r, d_py_r};

  // length
  logic              sq_v;
  logic [R_W-1:0]    sq_root;
  logic [TAG1_W-1:0] sq_tag_o;

  tlqe_sqrt_pipe #(
    .IN_W  (SQ_IN_W),
    .TAG_W (TAG1_W),
    .STEP  (SQRT_STEP)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d_v_r),
    .in_rad    (sq_rad),
    .in_tag    (sq_tag),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_tag   (sq_tag_o)
  );

  // offset magnitudes
  logic              dv_v;
  logic [Q_W-1:0]    dv_qx, dv_qy;
  logic [TAG2_W-1:0] dv_tag;

  tlqe_div_pipe #(
    .Q_W   (Q_W),
    .D_W   (D_W),
    .P_W   (P_W),
    .TAG_W (TAG2_W),
    .STEP  (DIV_STEP)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_v),
    .in_den    ({sq_root, 1'b0}),
    .in_px     (sq_tag_o[2*P_W-1:P_W]),
    .in_py     (sq_tag_o[P_W-1:0]),
    .in_tag    (sq_tag_o[TAG1_W-1:2*P_W]),
    .out_valid (dv_v),
    .out_qx    (dv_qx),
    .out_qy    (dv_qy),
    .out_tag   (dv_tag)
  );

  // stage e: corners
  logic [C-1:0]          t_x1, t_y1, t_x2, t_y2;
  logic                  t_sx, t_sy, t_thin, t_zero;
  logic signed [OFF_W-1:0] ox, oy;
  logic signed [CW-1:0]  oxe, oye, ax, ay, bx, by;
  logic                  e_v_r;
  logic                  e_thin_r;
  logic signed [CW-1:0]  e_cx_r[4];
  logic signed [CW-1:0]  e_cy_r[4];

  assign t_x1   = dv_tag[TAG2_W-1 -: C];
  assign t_y1   = dv_tag[TAG2_W-1-C -: C];
  assign t_x2   = dv_tag[TAG2_W-1-2*C -: C];
  assign t_y2   = dv_tag[TAG2_W-1-3*C -: C];
  assign t_sx   = dv_tag[3];
  assign t_sy   = dv_tag[2];
  assign t_thin = dv_tag[1];
  assign t_zero = dv_tag[0];

  always_comb begin
    if (t_thin || t_zero) begin
      ox = '0;
      oy = '0;
    end else begin
      ox = t_sx ? -$signed({1'b0, dv_qx}) : $signed({1'b0, dv_qx});
      oy = t_sy ? -$signed({1'b0, dv_qy}) : $signed({1'b0, dv_qy});
    end
  end

  assign oxe = {{(CW - OFF_W){ox[OFF_W-1]}}, ox};
  assign oye = {{(CW - OFF_W){oy[OFF_W-1]}}, oy};
  assign ax  = $signed({{2{t_x1[C-1]}}, t_x1, {F{1'b0}}}) - oxe;
  assign ay  = $signed({{2{t_y1[C-1]}}, t_y1, {F{1'b0}}}) - oye;
  assign bx  = $signed({{2{t_x2[C-1]}}, t_x2, {F{1'b0}}}) + oxe;
  assign by  = $signed({{2{t_y2[C-1]}}, t_y2, {F{1'b0}}}) + oye;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else begin
      e_v_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    e_thin_r  <= t_thin;
    e_cx_r[0] <= ax - oye;
    e_cy_r[0] <= ay + oxe;
    e_cx_r[1] <= ax + oye;
    e_cy_r[1] <= ay - oxe;
    e_cx_r[2] <= bx - oye;
    e_cy_r[2] <= by + oxe;
    e_cx_r[3] <= bx + oye;
    e_cy_r[3] <= by - oxe;
  end

  // vertex buffer and output serializer
  logic [C-1:0] vx_r[4];
  logic [C-1:0] vy_r[4];
  logic         s_thin_r;
  logic [2:0]   cnt_r, cnt_nxt;
  logic [1:0]   idx_r, idx_nxt;
  logic [1:0]   sel;

  logic               out_valid_r;
  logic [C-1:0]       out_x_r, out_y_r;
  logic               out_kind_r, out_last_r;

  assign sel = s_thin_r ? {idx_r[0], 1'b0} : idx_r;

  always_comb begin
    if (e_v_r) begin
      cnt_nxt = e_thin_r ? THIN_COUNT : THICK_COUNT;
      idx_nxt = 2'd0;
    end else if (cnt_r != 3'd0) begin
      cnt_nxt = cnt_r - 3'd1;
      idx_nxt = idx_r + 2'd1;
    end else begin
      cnt_nxt = cnt_r;
      idx_nxt = idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= 3'd0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= (cnt_r != 3'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (e_v_r) begin
      s_thin_r <= e_thin_r;
      for (int i = 0; i < 4; i++) begin
        vx_r[i] <= to_coord(e_cx_r[i]);
        vy_r[i] <= to_coord(e_cy_r[i]);
      end
    end
    out_x_r    <= vx_r[sel];
    out_y_r    <= vy_r[sel];
    out_kind_r <= s_thin_r ? KIND_LINE : KIND_STRIP;
    out_last_r <= (cnt_r == 3'd1);
  end

  assign out_valid          = out_valid_r;
  assign out_vertex_x       = out_x_r;
  assign out_vertex_y       = out_y_r;
  assign out_primitive_kind = out_kind_r;
  assign out_last_vertex    = out_last_r;

endmodule
